// ===== rtl/core/move_to_front_list_defines.svh =====
// ---------------------------------------------------------------------------
// move_to_front_list_defines
// assertion macros for the move-to-front list rtl
// ---------------------------------------------------------------------------
`ifndef MOVE_TO_FRONT_LIST_DEFINES_SVH
`define MOVE_TO_FRONT_LIST_DEFINES_SVH
`ifndef SYNTH
// property checked on every rising clock edge outside reset
`define MTFL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("move_to_front_list assertion failed");
// condition that must never be true outside reset
`define MTFL_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("move_to_front_list forbidden condition seen");
`else
`define MTFL_ASSERT(lbl, prop)
`define MTFL_NEVER(lbl, cond)
`endif
`endif

// ===== rtl/core/mtfl_pkg.sv =====
// ---------------------------------------------------------------------------
// mtfl_pkg
// types and codes shared by the move-to-front list and its cells
// ---------------------------------------------------------------------------
package mtfl_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FIND   = 1'b1;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FOUND     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic                      func;
        logic signed [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
    } t_out;

    // strobes broadcast to every cell
    typedef struct packed {
        logic               cmp;
        logic               ins;
        logic               move;
        logic               found;
        logic [VALUE_W-1:0] value;
    } t_cell_ctl;

endpackage

// ===== rtl/core/mtfl_cell.sv =====
// ---------------------------------------------------------------------------
// mtfl_cell
// one list slot: holds an entry, compares it, shifts in its neighbor's entry
// ---------------------------------------------------------------------------
module mtfl_cell
    import mtfl_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic               i_occ,
    input  logic [VALUE_W-1:0] i_prev_entry,
    input  logic               i_seen,
    output logic [VALUE_W-1:0] o_entry,
    output logic               o_seen,
    output logic               o_first
);

    logic [VALUE_W-1:0] r_entry;
    logic               r_hit;
    logic               w_take;

    // on a find only slots up to the first match move back
    assign w_take = i_ctl.ins || (i_ctl.move && i_ctl.found && !i_seen);

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_hit <= i_occ && (r_entry == i_ctl.value);
        end
        if (w_take) begin
            r_entry <= i_prev_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_seen  = i_seen || r_hit;
    assign o_first = r_hit && !i_seen;

endmodule

// ===== rtl/core/move_to_front_list.sv =====
// ---------------------------------------------------------------------------
// move_to_front_list
// self-organizing list of signed values kept in move-to-front order
// ---------------------------------------------------------------------------
// Usage: input beats carry func (insert or find) and a 32-bit value on
// i_in_data, handshaken by i_in_valid / o_in_ready. Each beat gives exactly
// one result beat on o_out_data (status, position) via o_out_valid /
// i_out_ready. Insert puts the value at the front unless the list holds
// CAPACITY entries (status full). Find reports the first match from the
// front and moves it there, or reports not found.
// Sequence: one beat is taken, then every cell compares its entry in the next
// cycle; once the output register is free, the row of cells shifts by one
// slot and the result is written to the output register. A new beat is taken
// only after the result of the previous one has been written, set by the
// compare-then-shift sequence through the cell row.
// Reset empties the list (entry count zero) and clears the output valid flag.
// If the receiver stalls, one result waits in the output register; a second
// finished beat holds in the shift step until that register frees up.
// ---------------------------------------------------------------------------
`include "move_to_front_list_defines.svh"

module move_to_front_list
    import mtfl_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_func;
    logic [VALUE_W-1:0] r_value;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;

    t_cell_ctl          w_ctl;
    logic               w_advance;
    logic               w_full;
    logic               w_found;
    logic [POS_W-1:0]   w_pos;
    logic [CAPACITY-1:0] w_occ;
    logic [CAPACITY-1:0] w_first;
    logic [CAPACITY:0]   w_seen;
    logic [VALUE_W-1:0]  w_entry [CAPACITY+1];

    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_advance = (r_state == S_UPD) && (!r_out_valid || i_out_ready);
    assign w_found   = w_seen[CAPACITY];

    assign w_ctl.cmp   = (r_state == S_CMP);
    assign w_ctl.ins   = w_advance && (r_func == FUNC_INSERT) && !w_full;
    assign w_ctl.move  = w_advance && (r_func == FUNC_FIND);
    assign w_ctl.found = w_found;
    assign w_ctl.value = r_value;

    // the front cell takes the new value; each later cell takes its neighbor's
    assign w_entry[0] = r_value;
    assign w_seen[0]  = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_occ[g] = (CNT_W'(g) < r_count);
        mtfl_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occ        (w_occ[g]),
            .i_prev_entry (w_entry[g]),
            .i_seen       (w_seen[g]),
            .o_entry      (w_entry[g+1]),
            .o_seen       (w_seen[g+1]),
            .o_first      (w_first[g])
        );
    end

    // first match is one-hot, so or-ing the indexes encodes it
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_first[i]) begin
                w_pos = w_pos | POS_W'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_advance) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out.position = '0;
                    if (r_func == FUNC_INSERT) begin
                        if (w_full) begin
                            n_out.status = ST_FULL;
                        end else begin
                            n_out.status = ST_INSERTED;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end else if (w_found) begin
                        n_out.status   = ST_FOUND;
                        n_out.position = w_pos;
                    end else begin
                        n_out.status = ST_NOT_FOUND;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_in_valid && o_in_ready) begin
            r_func  <= i_in_data.func;
            r_value <= i_in_data.value;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `MTFL_NEVER(a_count_bound, r_count > CNT_W'(CAPACITY))
    `MTFL_ASSERT(a_first_onehot, (r_state == S_UPD) |-> $onehot0(w_first))
    `MTFL_ASSERT(a_insert_grows, w_ctl.ins |=> (r_count == $past(r_count) + CNT_W'(1)))
    `MTFL_ASSERT(a_find_keeps_count, w_ctl.move |=> $stable(r_count))

endmodule

// ===== tb/sv/move_to_front_list_test.sv =====
// ---------------------------------------------------------------------------
// move_to_front_list_test
// self-checking bench for the move-to-front list: a short table of directed
// beats fills the list through its corner values and the full case, then
// random beats mostly look up stored values so matches land at every depth.
// Each result beat is checked field by field against the table or a local
// copy of the list; ready and valid idle at random in two of three phases.
// ---------------------------------------------------------------------------
module move_to_front_list_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mtfl_pkg::*;

    localparam int CAP            = 16;
    localparam int CLK_PERIOD     = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int HOLD_AT_RESULT = 500;
    localparam int HOLD_CYCLES    = 80;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    typedef struct {
        t_in  beat;
        bit   typed;
        t_out want;
    } dir_row_t;

    dir_row_t dir_rows[$];
    t_out     pending_results[$];

    // local copy of the list, front at index 0
    logic [VALUE_W-1:0] mtf_list [CAP];
    int                 mtf_count = 0;

    int unsigned sender_idle_pct = 0;
    int unsigned recv_idle_pct   = 0;
    int          mismatch_count  = 0;
    int          results_seen    = 0;
    int          hold_left       = 0;
    bit          hold_done       = 1'b0;
    int          stuck_cycles    = 0;

    move_to_front_list #(
        .CAPACITY(CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_out mtf_predict(input t_in beat);
        t_out r;
        int   hit;
        r.status   = ST_NOT_FOUND;
        r.position = '0;
        hit        = -1;
        if (beat.func == FUNC_INSERT) begin
            if (mtf_count >= CAP) begin
                r.status = ST_FULL;
            end else begin
                for (int i = mtf_count; i > 0; i--) mtf_list[i] = mtf_list[i-1];
                mtf_list[0] = beat.value;
                mtf_count++;
                r.status = ST_INSERTED;
            end
        end else begin
            for (int i = 0; i < mtf_count; i++) begin
                if (hit < 0 && mtf_list[i] == beat.value) hit = i;
            end
            if (hit >= 0) begin
                for (int k = hit; k > 0; k--) mtf_list[k] = mtf_list[k-1];
                mtf_list[0] = beat.value;
                r.status   = ST_FOUND;
                r.position = POS_W'(hit);
            end
        end
        return r;
    endfunction

    function automatic t_in next_random_beat();
        t_in         b;
        int unsigned roll;
        roll    = $urandom_range(99);
        b.func  = FUNC_FIND;
        b.value = $urandom;
        if (roll < 15) begin
            b.func = FUNC_INSERT;
        end else if (roll < 85 && mtf_count > 0) begin
            // look up something stored so the match depth varies
            b.value = mtf_list[$urandom_range(mtf_count - 1)];
        end
        return b;
    endfunction

    task automatic add_row(input logic f, input logic [VALUE_W-1:0] v, input bit typed,
                           input logic [1:0] st);
        dir_row_t row;
        row.beat.func      = f;
        row.beat.value     = v;
        row.typed          = typed;
        row.want.status    = st;
        row.want.position  = '0;
        dir_rows.push_back(row);
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic send_beat(input t_in beat, input bit typed, input t_out want);
        t_out got;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        got = mtf_predict(beat);
        pending_results.push_back(typed ? want : got);
    endtask

    // sender stops offering until every result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin : result_side
        t_out want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat: status %0d position %0d",
                                          o_out_data.status, o_out_data.position));
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              results_seen, o_out_data.status, want.status));
                if (o_out_data.position !== want.position)
                    report_mismatch($sformatf("result %0d position %0d, want %0d",
                                              results_seen, o_out_data.position,
                                              want.position));
            end
        end
        // one long hold-off so the list backs up and stalls its input
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles at %0t", WATCHDOG_LIMIT, $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        // empty list, corner values, duplicates, then fill to capacity and past it
        add_row(FUNC_FIND,   32'h0000_0000, 1'b1, ST_NOT_FOUND);
        add_row(FUNC_INSERT, 32'h8000_0000, 1'b1, ST_INSERTED);
        add_row(FUNC_FIND,   32'h8000_0000, 1'b0, ST_FOUND);
        add_row(FUNC_INSERT, 32'h7fff_ffff, 1'b1, ST_INSERTED);
        add_row(FUNC_FIND,   32'h8000_0000, 1'b0, ST_FOUND);
        add_row(FUNC_FIND,   32'h0000_0000, 1'b0, ST_NOT_FOUND);
        add_row(FUNC_INSERT, 32'h7fff_ffff, 1'b1, ST_INSERTED);
        add_row(FUNC_INSERT, 32'h0000_0000, 1'b1, ST_INSERTED);
        add_row(FUNC_INSERT, 32'hffff_ffff, 1'b1, ST_INSERTED);
        add_row(FUNC_INSERT, 32'h0000_0001, 1'b1, ST_INSERTED);
        add_row(FUNC_INSERT, 32'h5555_5555, 1'b1, ST_INSERTED);
        add_row(FUNC_INSERT, 32'haaaa_aaaa, 1'b1, ST_INSERTED);
        add_row(FUNC_FIND,   32'h7fff_ffff, 1'b0, ST_FOUND);
        add_row(FUNC_INSERT, 32'h0000_ffff, 1'b1, ST_INSERTED);
        add_row(FUNC_INSERT, 32'hffff_0000, 1'b1, ST_INSERTED);
        add_row(FUNC_INSERT, 32'h1234_5678, 1'b1, ST_INSERTED);
        add_row(FUNC_INSERT, 32'hedcb_a987, 1'b1, ST_INSERTED);
        add_row(FUNC_INSERT, 32'h0f0f_0f0f, 1'b1, ST_INSERTED);
        add_row(FUNC_INSERT, 32'hf0f0_f0f0, 1'b1, ST_INSERTED);
        add_row(FUNC_INSERT, 32'h0000_0002, 1'b1, ST_INSERTED);
        add_row(FUNC_INSERT, 32'hffff_fffe, 1'b1, ST_INSERTED);
        add_row(FUNC_INSERT, 32'h1357_9bdf, 1'b1, ST_FULL);
        add_row(FUNC_FIND,   32'h1357_9bdf, 1'b0, ST_NOT_FOUND);
        add_row(FUNC_FIND,   32'h8000_0000, 1'b0, ST_FOUND);
        add_row(FUNC_FIND,   32'h8000_0000, 1'b0, ST_FOUND);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 7;
        recv_idle_pct   = 60;
        foreach (dir_rows[k]) send_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want);
        repeat (RANDOM_PER_PHASE) send_beat(next_random_beat(), 1'b0, '0);
        drain_results();

        sender_idle_pct = 60;
        recv_idle_pct   = 7;
        repeat (RANDOM_PER_PHASE) send_beat(next_random_beat(), 1'b0, '0);
        drain_results();

        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        repeat (RANDOM_PER_PHASE) send_beat(next_random_beat(), 1'b0, '0);
        drain_results();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
